[src/atg_pkg.sv]
// Shared constants, types and table builder for the ACES tonemap and gamma block.
package atg_pkg;

    localparam int CHAN_W       = 24;
    localparam int CODE_W       = 8;
    localparam int GAIN_W       = 24;
    localparam int GAIN_RESET   = 65536;
    localparam int GAMMA_BITS_DEF = 12;
    localparam int THR_W        = 17;
    localparam int NUM_W        = 52;

    // ACES curve coefficients in Q.16
    localparam logic [17:0] ACES_A = 18'd164495;
    localparam logic [17:0] ACES_B = 18'd1966;
    localparam logic [17:0] ACES_C = 18'd159252;
    localparam logic [17:0] ACES_D = 18'd38666;
    localparam logic [17:0] ACES_E = 18'd9175;

    typedef logic [255:0][THR_W-1:0] t_thr_tab;

    // Smallest level v in 0..2^g with v^5 * 255^11 >= k^11 * 2^(5g);
    // that is the first level whose gamma code reaches k.
    function automatic logic [THR_W-1:0] gamma_thr(int k, int g);
        logic [191:0] rhs;
        logic [191:0] lhs;
        int lo;
        int hi;
        int mid;
        int n;
        rhs = 192'd1;
        for (n = 0; n < 11; n++) rhs = rhs * 192'(k);
        rhs = rhs << (5 * g);
        lo = 0;
        hi = 1 << g;
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            lhs = 192'd1;
            for (n = 0; n < 5; n++) lhs = lhs * 192'(mid);
            for (n = 0; n < 11; n++) lhs = lhs * 192'd255;
            if (lhs >= rhs) hi = mid;
            else lo = mid + 1;
        end
        return THR_W'(lo);
    endfunction

    function automatic t_thr_tab gamma_thr_tab(int g);
        t_thr_tab t;
        int k;
        t = '0;
        for (k = 0; k < 256; k++) t[k] = gamma_thr(k, g);
        return t;
    endfunction

endpackage

[src/atg_gamma.sv]
// Gamma encoder: pipelined binary search of the code thresholds, one code bit per stage.
module atg_gamma import atg_pkg::*; #(
    parameter int GAMMA_INDEX_BITS = GAMMA_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [GAMMA_INDEX_BITS:0] i_level,
    output logic [CODE_W-1:0]         o_code
);

    localparam t_thr_tab THR = gamma_thr_tab(GAMMA_INDEX_BITS);

    logic [GAMMA_INDEX_BITS:0] r_v    [1:CODE_W];
    logic [CODE_W-1:0]         r_code [1:CODE_W];

    for (genvar j = 0; j < CODE_W; j++) begin : g_step
        logic [GAMMA_INDEX_BITS:0] v_in;
        logic [CODE_W-1:0]         code_in;
        logic [CODE_W-1:0]         cand;
        logic                      take;
        if (j == 0) begin : g_first
            assign v_in    = i_level;
            assign code_in = '0;
        end else begin : g_next
            assign v_in    = r_v[j];
            assign code_in = r_code[j];
        end
        always_comb begin
            cand = code_in | (CODE_W'(1) << (CODE_W - 1 - j));
            take = THR[cand] <= THR_W'(v_in);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[j+1]    <= v_in;
                r_code[j+1] <= take ? cand : code_in;
            end
        end
    end

    assign o_code = r_code[CODE_W];

endmodule

[src/atg_lane.sv]
// One color lane: exposure gain, ACES curve, restoring divide and gamma encode.
module atg_lane import atg_pkg::*; #(
    parameter int GAMMA_INDEX_BITS = GAMMA_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [GAIN_W-1:0] i_gain,
    input  logic [CHAN_W-1:0] i_chan,
    output logic [CODE_W-1:0] o_code
);

    localparam int G = GAMMA_INDEX_BITS;

    logic [2*CHAN_W-1:0] r_prod;
    logic [CHAN_W-1:0]   r_x;
    logic [CHAN_W-1:0]   r_x2;
    logic [CHAN_W+17:0]  r_ax;
    logic [CHAN_W+17:0]  r_cx;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_dp;
    logic [25:0]         na;
    logic [25:0]         dc;
    logic [NUM_W-1:0]    den0;

    logic [NUM_W-1:0]    r_rem [0:G];
    logic [NUM_W-1:0]    r_den [0:G];
    logic [G-1:0]        r_q   [0:G];
    logic                r_sat [0:G];
    logic [G:0]          level;

    always_comb begin
        na   = 26'(r_ax >> 16) + 26'(ACES_B);
        dc   = 26'(r_cx >> 16) + 26'(ACES_D);
        den0 = r_dp + (NUM_W'(ACES_E) << 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= (2*CHAN_W)'(i_chan) * (2*CHAN_W)'(i_gain);
            // saturate a gained value of 256.0 or more
            r_x    <= (r_prod[47:40] != '0) ? {CHAN_W{1'b1}} : r_prod[39:16];
            r_ax   <= (CHAN_W+18)'(r_x) * (CHAN_W+18)'(ACES_A);
            r_cx   <= (CHAN_W+18)'(r_x) * (CHAN_W+18)'(ACES_C);
            r_x2   <= r_x;
            r_num  <= NUM_W'(r_x2) * NUM_W'(na);
            r_dp   <= NUM_W'(r_x2) * NUM_W'(dc);
            r_rem[0] <= r_num;
            r_den[0] <= den0;
            r_q[0]   <= '0;
            r_sat[0] <= r_num >= den0;
        end
    end

    for (genvar i = 0; i < G; i++) begin : g_div
        logic [NUM_W:0] sh;
        logic           ge;
        always_comb begin
            sh = {r_rem[i], 1'b0};
            ge = sh >= {1'b0, r_den[i]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= ge ? NUM_W'(sh - {1'b0, r_den[i]}) : NUM_W'(sh);
                r_den[i+1] <= r_den[i];
                r_q[i+1]   <= {r_q[i][G-2:0], ge};
                r_sat[i+1] <= r_sat[i];
            end
        end
    end

    // clamp the curve at 1.0
    assign level = r_sat[G] ? ((G+1)'(1) << G) : {1'b0, r_q[G]};

    atg_gamma #(.GAMMA_INDEX_BITS(G)) u_gamma (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_level (level),
        .o_code  (o_code)
    );

endmodule

[src/aces_tonemap_gamma_rgb8.sv]
// Top level: three tonemap lanes, shared control pipeline and exposure register.
// One pixel is accepted every clock cycle while the output is not stalled. The
// pipeline holds the gain and curve multiplier stages, one restoring divide stage
// per fractional level bit and one gamma search stage per code bit. A stall while
// a finished pixel waits at the output freezes the whole pipeline and is passed
// straight to o_stall. The exposure gain resets to 1.0 and is written with
// i_cfg_we; the user must write it only while the block is idle, and the block
// itself does not enforce this.
module aces_tonemap_gamma_rgb8 import atg_pkg::*; #(
    parameter int GAMMA_INDEX_BITS = GAMMA_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [GAIN_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAN_W-1:0] i_red_in,
    input  logic [CHAN_W-1:0] i_green_in,
    input  logic [CHAN_W-1:0] i_blue_in,
    input  logic              i_last_in,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [CODE_W-1:0] o_red_out,
    output logic [CODE_W-1:0] o_green_out,
    output logic [CODE_W-1:0] o_blue_out,
    output logic              o_last_out
);

    localparam int LAT = GAMMA_INDEX_BITS + 13;

    logic [GAIN_W-1:0] r_gain;
    logic [LAT-1:0]    r_vld;
    logic [LAT-1:0]    r_last;
    logic              en;

    // advance unless a finished pixel waits on a stalled output
    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_W'(GAIN_RESET);
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) r_gain <= i_cfg_wdata;
            if (en) r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_last <= {r_last[LAT-2:0], i_last_in};
    end

    atg_lane #(.GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)) u_red (
        .i_clk(i_clk), .i_en(en), .i_gain(r_gain), .i_chan(i_red_in), .o_code(o_red_out)
    );
    atg_lane #(.GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)) u_green (
        .i_clk(i_clk), .i_en(en), .i_gain(r_gain), .i_chan(i_green_in), .o_code(o_green_out)
    );
    atg_lane #(.GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)) u_blue (
        .i_clk(i_clk), .i_en(en), .i_gain(r_gain), .i_chan(i_blue_in), .o_code(o_blue_out)
    );

    assign o_valid    = r_vld[LAT-1];
    assign o_last_out = r_last[LAT-1];

endmodule

[dv/aces_tonemap_gamma_rgb8_tb.sv]
// Testbench for the ACES tonemap and gamma 2.2 pixel block: stimulus, prediction and checking.
`timescale 1ns / 1ps

module aces_tonemap_gamma_rgb8_tb;
    import atg_pkg::*;

    localparam int LEVEL_BITS = 12;
    localparam int LEVEL_ONE  = 1 << LEVEL_BITS;
    localparam int DOG_LIMIT  = 4000;
    localparam logic [23:0] CHAN_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } pixel_code_t;

    class tonemap_scoreboard;
        logic [7:0]       gamma_code [LEVEL_ONE+1];
        logic [23:0]      gain;
        pixel_code_t      pending [$];
        int               errors;

        function new();
            logic [319:0] lhs;
            logic [319:0] rhs;
            int k;
            int v;
            int n;
            gain = GAIN_RESET;
            errors = 0;
            k = 0;
            // largest k with k^22 * 2^(10G) <= v^10 * 255^22
            for (v = 0; v <= LEVEL_ONE; v++) begin
                rhs = 320'd1;
                for (n = 0; n < 10; n++) rhs = rhs * 320'(v);
                for (n = 0; n < 22; n++) rhs = rhs * 320'd255;
                while (k < 255) begin
                    lhs = 320'd1;
                    for (n = 0; n < 22; n++) lhs = lhs * 320'(k + 1);
                    lhs = lhs << (10 * LEVEL_BITS);
                    if (lhs <= rhs) k++;
                    else break;
                end
                gamma_code[v] = 8'(k);
            end
        endfunction

        function logic [7:0] map_channel(logic [23:0] radiance);
            logic [63:0] x;
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] level;
            x = (64'(radiance) * 64'(gain)) >> 16;
            if (x > 64'(CHAN_MAX)) x = 64'(CHAN_MAX);
            num = x * (((64'(ACES_A) * x) >> 16) + 64'(ACES_B));
            den = x * (((64'(ACES_C) * x) >> 16) + 64'(ACES_D)) + (64'(ACES_E) << 16);
            if (num >= den) level = LEVEL_ONE;
            else level = (num << LEVEL_BITS) / den;
            return gamma_code[level];
        endfunction

        function void note_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b, logic l);
            pixel_code_t e;
            e.red   = map_channel(r);
            e.green = map_channel(g);
            e.blue  = map_channel(b);
            e.last  = l;
            pending.push_back(e);
        endfunction

        function void check_pixel(pixel_code_t got);
            pixel_code_t e;
            if (pending.size() == 0) begin
                $error("unexpected output transfer: %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.red !== e.red) begin
                $error("red_out: expected %0d, got %0d", e.red, got.red);
                errors++;
            end
            if (got.green !== e.green) begin
                $error("green_out: expected %0d, got %0d", e.green, got.green);
                errors++;
            end
            if (got.blue !== e.blue) begin
                $error("blue_out: expected %0d, got %0d", e.blue, got.blue);
                errors++;
            end
            if (got.last !== e.last) begin
                $error("last_out: expected %0d, got %0d", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [GAIN_W-1:0] i_cfg_wdata = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [CHAN_W-1:0] i_red_in = '0;
    logic [CHAN_W-1:0] i_green_in = '0;
    logic [CHAN_W-1:0] i_blue_in = '0;
    logic              i_last_in = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [CODE_W-1:0] o_red_out;
    logic [CODE_W-1:0] o_green_out;
    logic [CODE_W-1:0] o_blue_out;
    logic              o_last_out;

    tonemap_scoreboard sb = new();
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    aces_tonemap_gamma_rgb8 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_last_out  (o_last_out)
    );

    // receive side: check transfers, stall at random, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_pixel({o_red_out, o_green_out, o_blue_out, o_last_out});
        if ((o_valid && !i_stall) || (i_valid && !o_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= DOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b, logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        i_last_in  <= l;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(r, g, b, l);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [23:0] g);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.gain = g;
    endtask

    function automatic logic [23:0] pick_radiance();
        case ($urandom_range(4))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 1 << 18));
            2: return 24'($urandom_range(0, 1 << 15));
            3: return 24'($urandom_range(0, 1 << 20));
            default: case ($urandom_range(3))
                0: return 24'd0;
                1: return 24'd1;
                2: return 24'd65536;
                default: return CHAN_MAX;
            endcase
        endcase
    endfunction

    logic [23:0] gain_plan [7] = '{24'd65536, 24'd0, 24'hFFFFFF, 24'd1,
                                   24'd16384, 24'd1048576, 24'd65536};
    int sent;

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes at the reset gain, then at zero gain and at the largest gain
        send_pixel(24'd0, 24'd0, 24'd0, 1'b0);
        send_pixel(CHAN_MAX, CHAN_MAX, CHAN_MAX, 1'b1);
        send_pixel(24'd1, 24'd65536, 24'h800000, 1'b0);
        send_pixel(24'd16384, 24'd32768, 24'd131072, 1'b1);
        send_pixel(24'd655360, 24'd6553600, 24'd300, 1'b0);
        send_pixel(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 1'b1);
        write_gain(24'd0);
        send_pixel(CHAN_MAX, 24'd65536, 24'd1, 1'b1);
        write_gain(24'hFFFFFF);
        send_pixel(CHAN_MAX, 24'd1, 24'd256, 1'b0);
        send_pixel(24'd0, 24'd2, 24'd65536, 1'b1);

        sent = 0;
        for (int ph = 0; ph < 7; ph++) begin
            write_gain(ph == 4 ? 24'($urandom) : gain_plan[ph]);
            for (int n = 0; n < 205; n++) begin
                if (sent < 480) begin
                    send_idle_pct = 17;
                    recv_stall_pct = 70;
                end else if (sent < 960) begin
                    send_idle_pct = 70;
                    recv_stall_pct = 17;
                end else begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                send_pixel(pick_radiance(), pick_radiance(), pick_radiance(),
                           1'($urandom));
                sent++;
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
